>>> rtl/wmis_pkg.sv
// wmis_pkg: commands, opcodes, status codes and sequencer states of the word machine
// no dependencies
`default_nettype none
package wmis_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ADDR_W = 9;
    localparam int unsigned STAT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 3'd0, CMD_RESTART = 3'd1, CMD_STEP = 3'd2,
        CMD_PEEK_MEM = 3'd3, CMD_PEEK_REG = 3'd4
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_HALT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADOP = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STAT_W-1:0] ST_DIV   = 3'd4;

    localparam logic [WORD_W-1:0] OP_MOVI = 32'd1;
    localparam logic [WORD_W-1:0] OP_MOV  = 32'd2;
    localparam logic [WORD_W-1:0] OP_ADD  = 32'd3;
    localparam logic [WORD_W-1:0] OP_SUB  = 32'd4;
    localparam logic [WORD_W-1:0] OP_MUL  = 32'd5;
    localparam logic [WORD_W-1:0] OP_IDIV = 32'd6;
    localparam logic [WORD_W-1:0] OP_JMP  = 32'd7;
    localparam logic [WORD_W-1:0] OP_JNZ  = 32'd8;
    localparam logic [WORD_W-1:0] OP_OUT  = 32'd9;
    localparam logic [WORD_W-1:0] OP_HALT = 32'd10;
    localparam logic [WORD_W-1:0] OP_LD   = 32'd11;
    localparam logic [WORD_W-1:0] OP_ST   = 32'd12;
    localparam logic [WORD_W-1:0] OP_JAL  = 32'd13;
    localparam logic [WORD_W-1:0] OP_RET  = 32'd14;
    localparam logic [WORD_W-1:0] OP_PUSH = 32'd15;
    localparam logic [WORD_W-1:0] OP_POP  = 32'd16;
    localparam logic [WORD_W-1:0] OP_LDLO = 32'd17;
    localparam logic [WORD_W-1:0] OP_STLO = 32'd18;

    localparam int unsigned REG_IP = 0;
    localparam int unsigned REG_RP = 29;
    localparam int unsigned REG_FP = 30;
    localparam int unsigned REG_SP = 31;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_RD_IP, S_WT_IP, S_F_OP, S_W_OP, S_F_A, S_W_A, S_F_B, S_W_B,
        S_DEC, S_RD_A, S_W_RA, S_RD_B, S_W_RB, S_RD_X, S_W_RX, S_EXEC, S_DIV,
        S_MEM, S_W_MEM, S_WB1, S_WB2, S_WB3, S_PEEK_R, S_W_PR, S_DONE
    } t_state;

    typedef struct packed {
        logic                start;
        logic [WORD_W-1:0]   dividend;
        logic [WORD_W-1:0]   divisor;
    } t_div_req;
endpackage
`default_nettype wire

>>> rtl/wmis_div.sv
// wmis_div: signed 32-bit divider, one quotient bit per cycle, truncating toward zero
// depends on wmis_pkg
`default_nettype none
module wmis_div
    import wmis_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_quot
);
    logic [WORD_W-1:0] r_q, n_q, r_d, n_d;
    logic [WORD_W:0]   r_rem, n_rem;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_neg, n_neg, r_busy, n_busy, r_done, n_done;
    logic [WORD_W:0]   sh, df;

    always_comb begin
        n_q = r_q; n_d = r_d; n_rem = r_rem; n_cnt = r_cnt; n_neg = r_neg;
        n_busy = r_busy; n_done = 1'b0;
        sh = {r_rem[WORD_W-1:0], r_q[WORD_W-1]};
        df = sh - {1'b0, r_d};
        if (i_req.start) begin
            n_q = i_req.dividend[WORD_W-1] ? (32'd0 - i_req.dividend) : i_req.dividend;
            n_d = i_req.divisor[WORD_W-1] ? (32'd0 - i_req.divisor) : i_req.divisor;
            n_neg = i_req.dividend[WORD_W-1] ^ i_req.divisor[WORD_W-1];
            n_rem = '0; n_cnt = 6'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!df[WORD_W]) begin
                n_rem = df; n_q = {r_q[WORD_W-2:0], 1'b1};
            end else begin
                n_rem = sh; n_q = {r_q[WORD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_d <= n_d; r_rem <= n_rem; r_cnt <= n_cnt; r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;
endmodule
`default_nettype wire

>>> rtl/word_machine_instruction_step.sv
// word_machine_instruction_step: command sequencer around a register file and word memory,
// both synchronous single-port memories; depends on wmis_pkg, wmis_div
// each command ends with the o_valid strobe in S_DONE; a step fetches the opcode and operands,
// reads registers, executes (IDIV waits in S_DIV) and writes back; busy through the strobe
// after reset a clearing pass zeroes every register of the register file, busy meanwhile
// the result is on the outputs for one cycle with o_valid; the receiver cannot stall
`default_nettype none
module word_machine_instruction_step
    import wmis_pkg::*;
#(
    parameter int unsigned MEM_WORDS = 512,
    parameter int unsigned NUM_REGS  = 32
)(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    i_cmd,
    input  wire logic [ADDR_W-1:0]   i_addr,
    input  wire logic [WORD_W-1:0]   i_data,
    output logic                     o_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_out_valid,
    output logic [WORD_W-1:0]        o_out_value,
    output logic [ADDR_W-1:0]        o_ip_now,
    output logic [WORD_W-1:0]        o_peek_value
);
    localparam int unsigned MA_W = $clog2(MEM_WORDS);
    localparam int unsigned RA_W = $clog2(NUM_REGS);
    localparam logic [WORD_W-1:0] MEM_LIM = WORD_W'(MEM_WORDS);
    localparam logic [WORD_W-1:0] REG_LIM = WORD_W'(NUM_REGS);
    localparam logic [RA_W-1:0] A_IP = RA_W'(REG_IP);
    localparam logic [RA_W-1:0] A_RP = RA_W'(REG_RP);
    localparam logic [RA_W-1:0] A_FP = RA_W'(REG_FP);
    localparam logic [RA_W-1:0] A_SP = RA_W'(REG_SP);

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rf  [NUM_REGS];
    logic [MA_W-1:0] mem_a; logic mem_we; logic [WORD_W-1:0] mem_wd, r_mem_q;
    logic [RA_W-1:0] rf_a;  logic rf_we;  logic [WORD_W-1:0] rf_wd, r_rf_q;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_a] <= mem_wd;
        r_mem_q <= mem[mem_a];
    end
    always_ff @(posedge i_clk) begin
        if (rf_we) rf[rf_a] <= rf_wd;
        r_rf_q <= rf[rf_a];
    end

    t_state r_st, n_st;
    logic [CMD_W-1:0] r_cmd; logic [ADDR_W-1:0] r_addr; logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] r_ip, n_ip, r_op, n_op, r_a, n_a, r_b, n_b;
    logic [WORD_W-1:0] r_ra, n_ra, r_rb, n_rb, r_rx, n_rx, r_res, n_res, r_pk, n_pk;
    logic [WORD_W-1:0] r_ipv, n_ipv;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic r_halt, n_halt, r_ov, n_ov;
    logic [RA_W-1:0] r_cc, n_cc;
    logic [WORD_W-1:0] r_ipc, n_ipc;
    t_div_req div_req; logic div_done; logic [WORD_W-1:0] div_q;

    wmis_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_done(div_done), .o_quot(div_q));

    function automatic logic needs_two(input logic [WORD_W-1:0] op);
        return op == OP_MOVI || op == OP_MOV || op == OP_ADD || op == OP_SUB ||
            op == OP_MUL || op == OP_IDIV || op == OP_JNZ || op == OP_LD ||
            op == OP_ST || op == OP_LDLO || op == OP_STLO;
    endfunction
    function automatic logic needs_one(input logic [WORD_W-1:0] op);
        return op == OP_JMP || op == OP_OUT || op == OP_JAL || op == OP_PUSH ||
            op == OP_POP;
    endfunction

    logic a_is_reg;
    assign a_is_reg = !(r_op == OP_MOVI || r_op == OP_LDLO || r_op == OP_STLO);

    always_comb begin
        n_st = r_st;
        n_ip = r_ip; n_op = r_op; n_a = r_a; n_b = r_b; n_ra = r_ra; n_rb = r_rb;
        n_rx = r_rx; n_res = r_res; n_pk = r_pk; n_stat = r_stat; n_halt = r_halt;
        n_ov = r_ov; n_cc = r_cc; n_ipc = r_ipc;
        n_ipv = r_ipv;
        mem_a = r_ip[MA_W-1:0]; mem_we = 1'b0; mem_wd = r_data;
        rf_a = A_IP; rf_we = 1'b0; rf_wd = '0;
        div_req = '{start: 1'b0, dividend: r_rb, divisor: r_ra};
        unique case (r_st)
            S_CLEAR: begin
                rf_a = r_cc; rf_we = 1'b1; rf_wd = '0; n_cc = r_cc + 1'b1;
                if (r_cc == RA_W'(NUM_REGS - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_stat = ST_OK; n_ov = 1'b0; n_res = '0; n_pk = '0;
                    n_st = S_RD_IP;
                end
            end
            S_RD_IP: begin
                rf_a = A_IP; n_st = S_WT_IP;
                unique case (r_cmd)
                    CMD_LOAD: begin
                        if (32'(r_addr) < MEM_LIM) begin
                            mem_a = MA_W'(r_addr); mem_we = 1'b1; mem_wd = r_data;
                        end else n_stat = ST_RANGE;
                    end
                    CMD_RESTART: begin
                        rf_we = 1'b1; rf_wd = '0; n_halt = 1'b0; n_st = S_WB2;
                    end
                    CMD_PEEK_MEM: begin
                        if (32'(r_addr) < MEM_LIM) begin
                            mem_a = MA_W'(r_addr); n_st = S_W_MEM;
                        end else n_stat = ST_RANGE;
                    end
                    CMD_PEEK_REG: begin
                        if (32'(r_addr) < REG_LIM) begin
                            rf_a = RA_W'(r_addr); n_st = S_W_PR;
                        end else n_stat = ST_RANGE;
                    end
                    default: ;
                endcase
            end
            S_WT_IP: begin
                n_ipc = r_rf_q;
                if (r_cmd == CMD_STEP) begin
                    n_ip = r_rf_q;
                    if (r_halt) begin n_stat = ST_HALT; n_st = S_DONE; end
                    else n_st = S_F_OP;
                end else n_st = S_DONE;
            end
            S_W_PR: begin n_pk = r_rf_q; n_st = S_DONE; end
            S_W_MEM: begin
                if (r_cmd == CMD_PEEK_MEM) begin n_pk = r_mem_q; n_st = S_DONE; end
                else begin
                    n_res = r_mem_q;
                    if (r_op == OP_POP) n_st = S_WB1; else n_st = S_WB2;
                end
            end
            S_F_OP: begin
                if (r_ip >= MEM_LIM) begin n_stat = ST_RANGE; n_st = S_DONE; end
                else begin mem_a = r_ip[MA_W-1:0]; n_ip = r_ip + 1; n_st = S_W_OP; end
            end
            S_W_OP: begin
                n_op = r_mem_q;
                if (needs_two(r_mem_q) || needs_one(r_mem_q)) n_st = S_F_A;
                else if (r_mem_q == OP_HALT) begin
                    n_halt = 1'b1; n_stat = ST_HALT; n_st = S_DONE;
                end else if (r_mem_q == OP_RET) n_st = S_DEC;
                else begin n_stat = ST_BADOP; n_st = S_DONE; end
            end
            S_F_A: begin
                if (r_ip >= MEM_LIM) begin n_stat = ST_RANGE; n_st = S_DONE; end
                else begin mem_a = r_ip[MA_W-1:0]; n_ip = r_ip + 1; n_st = S_W_A; end
            end
            S_W_A: begin
                n_a = r_mem_q;
                n_st = needs_two(r_op) ? S_F_B : S_DEC;
            end
            S_F_B: begin
                if (r_ip >= MEM_LIM) begin n_stat = ST_RANGE; n_st = S_DONE; end
                else begin mem_a = r_ip[MA_W-1:0]; n_ip = r_ip + 1; n_st = S_W_B; end
            end
            S_W_B: begin n_b = r_mem_q; n_st = S_DEC; end
            S_DEC: begin
                if (needs_two(r_op) && (r_b >= REG_LIM || (a_is_reg && r_a >= REG_LIM))) begin
                    n_stat = ST_RANGE; n_st = S_DONE;
                end else if (needs_one(r_op) && r_a >= REG_LIM) begin
                    n_stat = ST_RANGE; n_st = S_DONE;
                end else n_st = S_RD_A;
            end
            S_RD_A: begin rf_a = r_a[RA_W-1:0]; n_st = S_W_RA; end
            S_W_RA: begin n_ra = r_rf_q; n_st = S_RD_B; end
            S_RD_B: begin rf_a = r_b[RA_W-1:0]; n_st = S_W_RB; end
            S_W_RB: begin n_rb = r_rf_q; n_st = S_RD_X; end
            S_RD_X: begin
                rf_a = (r_op == OP_RET) ? A_RP :
                       (r_op == OP_PUSH || r_op == OP_POP) ? A_SP : A_FP;
                n_st = S_W_RX;
            end
            S_W_RX: begin n_rx = r_rf_q; n_st = S_EXEC; end
            S_EXEC: begin
                n_ipv = r_ip; n_st = S_WB2;
                priority case (1'b1)
                    r_op == OP_MOVI: n_res = r_a;
                    r_op == OP_MOV:  n_res = r_ra;
                    r_op == OP_ADD:  n_res = r_rb + r_ra;
                    r_op == OP_SUB:  n_res = r_rb - r_ra;
                    r_op == OP_MUL:  begin n_st = S_MEM; n_res = r_rb * r_ra; end
                    r_op == OP_IDIV: begin
                        if (r_ra == '0) begin n_stat = ST_DIV; n_st = S_DONE; end
                        else begin div_req.start = 1'b1; n_st = S_DIV; end
                    end
                    r_op == OP_JMP: begin n_ipv = r_ra; n_st = S_WB3; end
                    r_op == OP_JNZ: begin
                        if (r_ra != '0) n_ipv = r_rb;
                        n_st = S_WB3;
                    end
                    r_op == OP_OUT: begin n_ov = 1'b1; n_res = r_ra; n_st = S_WB3; end
                    r_op == OP_RET: begin n_ipv = r_rx; n_st = S_WB3; end
                    r_op == OP_JAL: begin
                        // the target acts as if the return pointer were written before it is read
                        n_res = r_ip;
                        n_ipv = (r_a == WORD_W'(REG_RP)) ? r_ip : r_ra;
                        n_st = S_WB1;
                    end
                    r_op == OP_LD || r_op == OP_ST: begin
                        if (r_ra >= MEM_LIM) begin n_stat = ST_RANGE; n_st = S_DONE; end
                        else begin n_rx = r_ra; n_res = r_rb; n_st = S_MEM; end
                    end
                    r_op == OP_LDLO || r_op == OP_STLO: begin
                        if (r_rx + r_a >= MEM_LIM) begin n_stat = ST_RANGE; n_st = S_DONE; end
                        else begin n_rx = r_rx + r_a; n_res = r_rb; n_st = S_MEM; end
                    end
                    r_op == OP_PUSH: begin
                        if (r_rx >= MEM_LIM) begin n_stat = ST_RANGE; n_st = S_DONE; end
                        else begin n_res = r_ra; n_st = S_MEM; end
                    end
                    default: begin
                        if (r_rx - 1 >= MEM_LIM) begin n_stat = ST_RANGE; n_st = S_DONE; end
                        else begin n_rx = r_rx - 1; n_st = S_MEM; end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin n_res = div_q; n_st = S_WB2; end
            end
            S_MEM: begin
                mem_a = r_rx[MA_W-1:0];
                priority case (1'b1)
                    r_op == OP_MUL: n_st = S_WB2;
                    r_op == OP_ST || r_op == OP_STLO || r_op == OP_PUSH: begin
                        mem_we = 1'b1; mem_wd = r_res;
                        if (r_op == OP_PUSH) begin
                            n_res = r_rx + 1; n_st = S_WB1;
                        end else n_st = S_WB3;
                    end
                    default: n_st = S_W_MEM;
                endcase
            end
            S_WB1: begin
                // stack pointer or return pointer
                rf_we = 1'b1;
                if (r_op == OP_JAL) begin rf_a = A_RP; rf_wd = r_res; n_st = S_WB3; end
                else if (r_op == OP_PUSH) begin rf_a = A_SP; rf_wd = r_res; n_st = S_WB3; end
                else begin rf_a = A_SP; rf_wd = r_rx; n_st = S_WB2; end
            end
            S_WB2: begin
                rf_we = 1'b1;
                if (r_cmd == CMD_RESTART) begin
                    rf_a = A_FP; rf_wd = r_data; n_st = S_WB3;
                end else begin
                    rf_a = (r_op == OP_POP) ? r_a[RA_W-1:0] : r_b[RA_W-1:0];
                    rf_wd = r_res; n_st = S_WB3;
                end
            end
            S_WB3: begin
                rf_we = 1'b1; n_st = S_DONE;
                if (r_cmd == CMD_RESTART) begin
                    rf_a = A_SP; rf_wd = r_data; n_ipc = '0;
                end else begin
                    rf_a = A_IP; rf_wd = r_ipv; n_ipc = r_ipv;
                end
                if (r_cmd != CMD_RESTART && r_op != OP_OUT) n_res = '0;
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_cc <= '0; r_halt <= 1'b0; r_ipc <= '0;
        end else begin
            r_st <= n_st; r_cc <= n_cc; r_halt <= n_halt; r_ipc <= n_ipc;
        end
        if (r_st == S_IDLE && start) begin
            r_cmd <= i_cmd; r_addr <= i_addr; r_data <= i_data; r_op <= '0;
        end else r_op <= n_op;
        r_ip <= n_ip; r_a <= n_a; r_b <= n_b; r_ra <= n_ra; r_rb <= n_rb;
        r_rx <= n_rx; r_res <= n_res; r_pk <= n_pk; r_stat <= n_stat; r_ov <= n_ov;
        r_ipv <= n_ipv;
    end

    assign busy         = (r_st != S_IDLE);
    assign o_valid      = (r_st == S_DONE);
    assign o_status     = r_stat;
    assign o_out_valid  = r_ov && r_stat == ST_OK;
    assign o_out_value  = (r_ov && r_stat == ST_OK) ? r_res : '0;
    assign o_ip_now     = r_ipc[ADDR_W-1:0];
    assign o_peek_value = r_pk;
endmodule
`default_nettype wire
